// ===== rtl/core/sliding_window_median_unit_defines.svh =====
// Assertion macros used by the top-level RTL file.
`ifndef SLIDING_WINDOW_MEDIAN_UNIT_DEFINES_SVH
`define SLIDING_WINDOW_MEDIAN_UNIT_DEFINES_SVH

`ifndef SYNTH
`define SWM_ASSERT(lbl, clk, rst, prop) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error("sliding window median assertion failed");
`define SWM_ASSERT_ALWAYS(lbl, clk, prop) \
  lbl: assert property (@(posedge clk) prop) \
    else $error("sliding window median assertion failed");
`else
`define SWM_ASSERT(lbl, clk, rst, prop)
`define SWM_ASSERT_ALWAYS(lbl, clk, prop)
`endif

`endif

// ===== rtl/core/swm_pkg.sv =====
package swm_pkg;

  localparam int MAX_WINDOW = 64;
  localparam int DATA_W = 32;
  localparam int IDX_W = $clog2(MAX_WINDOW);
  localparam int CNT_W = $clog2(MAX_WINDOW + 1);

  typedef struct packed {
    logic start;
    logic remove;
    logic insert;
    logic load;
  } swm_cmd_t;

  typedef struct packed {
    logic has_result;
  } swm_sts_t;

endpackage

// ===== rtl/core/sliding_window_median_unit.sv =====
// A beat accepted in S_IDLE passes S_REMOVE, S_INSERT and S_EMIT, where its median is loaded
// if the window is full and the output is free. No new sample is taken before S_IDLE, that is,
// until the history memory read, the removal and insertion passes over the sorted cell row and
// any output stall are done. Reset (rst, synchronous) sets win to 1, empties the window and
// drops any result; the history memory and sorted cells are not cleared.
`include "sliding_window_median_unit_defines.svh"

module sliding_window_median_unit (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              cfg_we,
  input  logic [swm_pkg::CNT_W-1:0]         cfg_wdata,
  input  logic                              s_tvalid,
  output logic                              s_tready,
  input  logic signed [swm_pkg::DATA_W-1:0] s_tdata,  // [31:0] sample
  input  logic                              s_tuser,  // [0] restart
  output logic                              m_tvalid,
  input  logic                              m_tready,
  output logic signed [swm_pkg::DATA_W-1:0] m_tdata   // [31:0] median
);
  import swm_pkg::*;

  swm_cmd_t cmd;
  swm_sts_t sts;

  swm_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s_tvalid),
    .in_ready  (s_tready),
    .out_valid (m_tvalid),
    .out_ready (m_tready),
    .sts       (sts),
    .cmd       (cmd)
  );

  swm_dpath u_dpath (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .sample    (s_tdata),
    .restart   (s_tuser),
    .cmd       (cmd),
    .sts       (sts),
    .median    (m_tdata)
  );

  `SWM_ASSERT(a_start_on_beat, clk, rst, cmd.start |-> (s_tvalid && s_tready))
  `SWM_ASSERT(a_no_overwrite, clk, rst, cmd.load |-> (!m_tvalid || m_tready))
  `SWM_ASSERT(a_busy_after_beat, clk, rst, (s_tvalid && s_tready) |=> !s_tready)
  `SWM_ASSERT(a_one_cmd, clk, rst, $onehot0({cmd.start, cmd.remove, cmd.insert, cmd.load}))

endmodule

// ===== rtl/core/swm_ctrl.sv =====
module swm_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  output logic              out_valid,
  input  logic              out_ready,
  input  swm_pkg::swm_sts_t sts,
  output swm_pkg::swm_cmd_t cmd
);
  import swm_pkg::*;

  typedef enum logic [1:0] {
    S_IDLE,
    S_REMOVE,
    S_INSERT,
    S_EMIT
  } state_t;

  state_t state;
  logic   can_load;

  assign in_ready = (state == S_IDLE);
  assign can_load = !out_valid || out_ready;

  always_comb begin
    cmd = '0;
    cmd.start  = (state == S_IDLE) && in_valid;
    cmd.remove = (state == S_REMOVE);
    cmd.insert = (state == S_INSERT);
    cmd.load   = (state == S_EMIT) && sts.has_result && can_load;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      if (out_valid && out_ready && !cmd.load) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (in_valid) begin
            state <= S_REMOVE;
          end
        end
        S_REMOVE: begin
          state <= S_INSERT;
        end
        S_INSERT: begin
          state <= S_EMIT;
        end
        S_EMIT: begin
          if (!sts.has_result) begin
            state <= S_IDLE;
          end else if (can_load) begin
            out_valid <= 1'b1;
            state     <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

// ===== rtl/core/swm_dpath.sv =====
module swm_dpath (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              cfg_we,
  input  logic [swm_pkg::CNT_W-1:0]         cfg_wdata,
  input  logic signed [swm_pkg::DATA_W-1:0] sample,
  input  logic                              restart,
  input  swm_pkg::swm_cmd_t                 cmd,
  output swm_pkg::swm_sts_t                 sts,
  output logic signed [swm_pkg::DATA_W-1:0] median
);
  import swm_pkg::*;

  logic [CNT_W-1:0]         win;
  logic [IDX_W-1:0]         med_idx;
  logic [CNT_W-1:0]         fill;
  logic [IDX_W-1:0]         wpos;
  logic                     full_q;
  logic signed [DATA_W-1:0] cur;
  logic signed [DATA_W-1:0] hist_q;
  logic signed [DATA_W-1:0] hist_mem [MAX_WINDOW];
  logic signed [DATA_W-1:0] cells [MAX_WINDOW];
  logic signed [DATA_W-1:0] cells_next [MAX_WINDOW];

  logic [CNT_W-1:0]    cfg_eff;
  logic                clr;
  logic [CNT_W-1:0]    fill_eff;
  logic [IDX_W-1:0]    pos_eff;
  logic [CNT_W-1:0]    pos_inc;
  logic [MAX_WINDOW-1:0] vld;
  logic [MAX_WINDOW-1:0] eq;
  logic [MAX_WINDOW-1:0] gt;
  logic [MAX_WINDOW-1:0] rm_shift;
  logic                found;
  logic                do_remove;
  logic                do_insert;

  always_comb begin
    if (cfg_wdata == '0) begin
      cfg_eff = CNT_W'(1);
    end else if (cfg_wdata > CNT_W'(MAX_WINDOW)) begin
      cfg_eff = CNT_W'(MAX_WINDOW);
    end else begin
      cfg_eff = cfg_wdata;
    end
  end

  assign clr      = restart || (fill > win);
  assign fill_eff = clr ? '0 : fill;
  assign pos_eff  = (clr || ({1'b0, wpos} >= win)) ? '0 : wpos;
  assign pos_inc  = {1'b0, pos_eff} + CNT_W'(1);

  always_comb begin
    for (int i = 0; i < MAX_WINDOW; i++) begin
      vld[i] = CNT_W'(i) < fill;
      eq[i]  = vld[i] && (cells[i] == hist_q);
      gt[i]  = vld[i] && (cells[i] > cur);
    end
    for (int i = 0; i < MAX_WINDOW; i++) begin
      rm_shift[i] = |(eq & ((MAX_WINDOW'(2) << i) - MAX_WINDOW'(1)));
    end
  end

  assign found     = |eq;
  assign do_remove = cmd.remove && full_q && found;
  assign do_insert = cmd.insert && (fill < CNT_W'(MAX_WINDOW));

  always_comb begin
    for (int i = 0; i < MAX_WINDOW; i++) begin
      cells_next[i] = cells[i];
      if (do_remove) begin
        if (rm_shift[i] && (i < MAX_WINDOW - 1)) begin
          cells_next[i] = cells[(i + 1) % MAX_WINDOW];
        end
      end else if (do_insert) begin
        if (gt[i] || (CNT_W'(i) == fill)) begin
          if ((i > 0) && gt[(i + MAX_WINDOW - 1) % MAX_WINDOW]) begin
            cells_next[i] = cells[(i + MAX_WINDOW - 1) % MAX_WINDOW];
          end else begin
            cells_next[i] = cur;
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < MAX_WINDOW; i++) begin
      cells[i] <= cells_next[i];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.start) begin
      hist_q            <= hist_mem[pos_eff];
      hist_mem[pos_eff] <= sample;
      cur               <= sample;
    end
    if (cmd.load) begin
      median <= cells[med_idx];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      win     <= CNT_W'(1);
      med_idx <= '0;
      fill    <= '0;
      wpos    <= '0;
      full_q  <= 1'b0;
    end else if (cfg_we) begin
      win     <= cfg_eff;
      med_idx <= IDX_W'((cfg_eff - CNT_W'(1)) >> 1);
      fill    <= '0;
      wpos    <= '0;
    end else if (cmd.start) begin
      fill   <= fill_eff;
      full_q <= (fill_eff == win);
      wpos   <= (pos_inc >= win) ? '0 : pos_inc[IDX_W-1:0];
    end else if (do_remove) begin
      fill <= fill - CNT_W'(1);
    end else if (do_insert) begin
      fill <= fill + CNT_W'(1);
    end
  end

  always_comb begin
    sts = '0;
    sts.has_result = (fill == win);
  end

endmodule
